>>> hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define FFUA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define FFUA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ffua_pkg.sv
// Shared types and constants of the first-fit unit allocator.
// No dependencies; used by the engine, the top level and the checker.
`timescale 1ns / 1ps

package ffua_pkg;

  // Map geometry.
  localparam int NUM_UNITS  = 1024;
  localparam int OWNER_BITS = 8;
  localparam int UNIT_AW    = $clog2(NUM_UNITS);
  localparam int CNT_W      = $clog2(NUM_UNITS + 1);

  // Field widths of the request and the result.
  localparam int OWNER_ID_W = 8;
  localparam int SIZE_W     = 11;
  localparam int START_W    = 10;
  localparam int CMP_W      = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((OWNER_ID_W + SIZE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((START_W + 7) / 8) * 8;

  localparam logic [UNIT_AW-1:0] LAST_ADDR = UNIT_AW'(NUM_UNITS - 1);

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOTHING   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ES_CLEAR,
    ES_IDLE,
    ES_ALLOC_SCAN,
    ES_ALLOC_FILL,
    ES_REL_SCAN,
    ES_RESULT
  } eng_state_t;

  // One entry of the ownership map.
  typedef struct packed {
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } map_entry_t;

  typedef struct packed {
    mode_t                 mode;
    logic [OWNER_ID_W-1:0] owner_id;
    logic [SIZE_W-1:0]     request_size;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [START_W-1:0]   start_unit;
  } res_t;

  // Engine status seen by the stream wrapper.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

>>> hdl/first_fit_unit_allocator.sv
// Top level of the first-fit unit allocator: stream ports and the result register.
// Depends on ffua_pkg and ffua_engine.
`timescale 1ns / 1ps
//
// Usage
// The in_ channel takes one request at a time. in_tuser is the mode (allocate or
// release), in_tdata carries the owner id and the wanted run length. Every request
// gives exactly one result on the out_ channel: out_tuser is the status, out_tdata
// the first unit of an allocated run (zero otherwise).
// The run time of a request is set by the single read port of the map memory, which
// reads one entry a cycle:
//   allocate with a zero or oversized length: no scan, straight to the result;
//   allocate: the map is scanned up to the end of the run found, then each unit of
//   the run is marked, then the result goes to the output;
//   allocate with no room, and release: the whole map is scanned.
// One request is in work at a time; in_tready is high while the engine is idle.
// After reset the map is cleared to all free, one entry a cycle, through all NUM_UNITS
// entries (1024), during which in_tready stays low.
// A result waits in the output register while out_tready is low; the next request
// is still accepted and worked on, and its result waits in the engine until the
// output register is free.

module first_fit_unit_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ffua_pkg::IN_TDATA_W-1:0]  in_tdata,   // owner_id, request_size, zero pad
  input  logic                             in_tuser,   // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffua_pkg::OUT_TDATA_W-1:0] out_tdata,  // start_unit, zero pad
  output logic [1:0]                       out_tuser   // status
);
  import ffua_pkg::*;

  req_t      req;
  res_t      eng_res;
  eng_stat_t eng_stat;
  logic      in_fire;
  logic      res_take;

  logic      out_tvalid_r;
  res_t      out_res_r;

  // Request unpacking.
  assign req.mode         = mode_t'(in_tuser);
  assign req.owner_id     = in_tdata[OWNER_ID_W-1:0];
  assign req.request_size = in_tdata[OWNER_ID_W +: SIZE_W];

  assign in_tready = eng_stat.idle;
  assign in_fire   = in_tvalid && in_tready;
  assign res_take  = eng_stat.res_valid && (!out_tvalid_r || out_tready);

  ffua_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .req      (req),
    .res_take (res_take),
    .stat     (eng_stat),
    .res      (eng_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r.start_unit);
  assign out_tuser  = out_res_r.status;

endmodule

>>> hdl/ffua_engine.sv
// Scan engine: ownership map memory plus the sequencer that clears, scans and updates it.
// Depends on ffua_pkg.
`timescale 1ns / 1ps

module ffua_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ffua_pkg::req_t    req,
  input  logic              res_take,
  output ffua_pkg::eng_stat_t stat,
  output ffua_pkg::res_t    res
);
  import ffua_pkg::*;

  // Map memory: one write port, one registered read port.
  map_entry_t map_mem [NUM_UNITS];
  map_entry_t rd_data_r;

  logic               rd_en;
  logic               wr_en;
  logic [UNIT_AW-1:0] wr_addr;
  map_entry_t         wr_data;

  eng_state_t state_r, state_nxt;
  logic [UNIT_AW-1:0] addr_r, addr_nxt;
  logic               issue_r, issue_nxt;
  logic               rd_vld_r;
  logic [UNIT_AW-1:0] chk_addr_r;
  logic [UNIT_AW-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0]   run_len_r, run_len_nxt;
  logic [CNT_W-1:0]   want_r, want_nxt;
  logic [CNT_W-1:0]   fill_left_r, fill_left_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic               found_r, found_nxt;
  res_t               res_r, res_nxt;

  logic [CNT_W-1:0]   len_inc;
  logic [UNIT_AW-1:0] cand_start;
  logic [CMP_W-1:0]   size_ext;
  logic               hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= map_mem[addr_r];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ES_CLEAR;
      addr_r   <= '0;
      issue_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      issue_r  <= issue_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    chk_addr_r  <= addr_r;
    run_start_r <= run_start_nxt;
    run_len_r   <= run_len_nxt;
    want_r      <= want_nxt;
    fill_left_r <= fill_left_nxt;
    owner_r     <= owner_nxt;
    found_r     <= found_nxt;
    res_r       <= res_nxt;
  end

  assign len_inc    = run_len_r + CNT_W'(1);
  assign cand_start = (run_len_r == '0) ? chk_addr_r : run_start_r;
  assign size_ext   = CMP_W'(req.request_size);
  assign hit        = rd_vld_r && !rd_data_r.free && (rd_data_r.owner == owner_r);

  // Sequencer. Reads of a scan lead its write-backs by one address, so a
  // read never meets a pending write to the same entry.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    want_nxt      = want_r;
    fill_left_nxt = fill_left_r;
    owner_nxt     = owner_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = '0;

    case (state_r)
      ES_CLEAR: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ES_IDLE;
        end else begin
          addr_nxt = addr_r + UNIT_AW'(1);
        end
      end

      ES_IDLE: begin
        if (start) begin
          owner_nxt   = OWNER_BITS'(req.owner_id);
          run_len_nxt = '0;
          found_nxt   = 1'b0;
          addr_nxt    = '0;
          issue_nxt   = 1'b1;
          want_nxt    = CNT_W'(req.request_size);
          res_nxt     = '0;
          if (req.mode == MODE_RELEASE) begin
            state_nxt = ES_REL_SCAN;
          end else if (size_ext == '0 || size_ext > CMP_W'(NUM_UNITS)) begin
            issue_nxt      = 1'b0;
            res_nxt.status = ST_NO_ROOM;
            state_nxt      = ES_RESULT;
          end else begin
            state_nxt = ES_ALLOC_SCAN;
          end
        end
      end

      ES_ALLOC_SCAN: begin
        rd_en = issue_r;
        if (issue_r) begin
          if (addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + UNIT_AW'(1);
          end
        end
        if (rd_vld_r) begin
          if (rd_data_r.free) begin
            run_start_nxt = cand_start;
            run_len_nxt   = len_inc;
          end else begin
            run_len_nxt = '0;
          end
          // Run long enough: stop reading and mark it.
          if (rd_data_r.free && len_inc >= want_r) begin
            issue_nxt          = 1'b0;
            addr_nxt           = cand_start;
            fill_left_nxt      = want_r;
            res_nxt.status     = ST_ALLOCATED;
            res_nxt.start_unit = START_W'(cand_start);
            state_nxt          = ES_ALLOC_FILL;
          end else if (chk_addr_r == LAST_ADDR) begin
            res_nxt.status     = ST_NO_ROOM;
            res_nxt.start_unit = '0;
            state_nxt          = ES_RESULT;
          end
        end
      end

      ES_ALLOC_FILL: begin
        wr_en         = 1'b1;
        wr_data.free  = 1'b0;
        wr_data.owner = owner_r;
        addr_nxt      = addr_r + UNIT_AW'(1);
        fill_left_nxt = fill_left_r - CNT_W'(1);
        if (fill_left_r == CNT_W'(1)) begin
          state_nxt = ES_RESULT;
        end
      end

      ES_REL_SCAN: begin
        rd_en = issue_r;
        if (issue_r) begin
          if (addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + UNIT_AW'(1);
          end
        end
        // Free every unit of the owner as its entry comes back.
        if (hit) begin
          wr_en         = 1'b1;
          wr_addr       = chk_addr_r;
          wr_data.free  = 1'b1;
          wr_data.owner = rd_data_r.owner;
        end
        found_nxt = found_r | hit;
        if (rd_vld_r && chk_addr_r == LAST_ADDR) begin
          res_nxt.status     = (found_r | hit) ? ST_RELEASED : ST_NOTHING;
          res_nxt.start_unit = '0;
          state_nxt          = ES_RESULT;
        end
      end

      ES_RESULT: begin
        if (res_take) begin
          state_nxt = ES_IDLE;
        end
      end

      default: begin
        state_nxt = ES_IDLE;
      end
    endcase
  end

  assign stat.idle      = (state_r == ES_IDLE);
  assign stat.res_valid = (state_r == ES_RESULT);
  assign res            = res_r;

endmodule

>>> hdl/ffua_checker.sv
// Port-level checks of the first-fit unit allocator, bound to the top level.
// Depends on ffua_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffua_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ffua_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffua_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser
);
  import ffua_pkg::*;

  // A stalled result stays offered.
  `FFUA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // Only one request is in work: ready drops after each accepted request.
  `FFUA_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

  // The start unit is zero unless a run was allocated.
  `FFUA_ASSERT(a_start_zero, out_tvalid && out_tuser != ST_ALLOCATED |-> out_tdata == '0, "nonzero start unit")

  // Reset empties the output register.
  `FFUA_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "result valid after reset")

  // The map is cleared after reset before the first request is taken.
  `FFUA_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> !in_tready, "request taken during map clear")

endmodule

bind first_fit_unit_allocator ffua_checker u_ffua_checker (.*);
